### rtl/tkss_pkg.sv
// ----------------------------------------------------------------------------
// tkss_pkg
// Shared types and constants of the truncation top-k selector.
// ----------------------------------------------------------------------------
package tkss_pkg;

   localparam int FIT_W          = 32;
   localparam int POS_W          = 6;
   localparam int CFG_W          = 7;
   localparam int CSR_ADDR_W     = 4;

   localparam int POP_MAX_DEF    = 64;
   localparam int GENE_BITS_DEF  = 32;
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [CSR_ADDR_W-1:0] REG_POP_SIZE     = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] REG_SELECT_COUNT = CSR_ADDR_W'(1);

   localparam logic [CFG_W-1:0] POP_SIZE_RST     = CFG_W'(64);
   localparam logic [CFG_W-1:0] SELECT_COUNT_RST = CFG_W'(32);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_HEAD,
      ST_SCAN,
      ST_GENE,
      ST_EMIT
   } back_state_type;

   // classification of one load request, passed from front to back
   typedef struct packed {
      logic [POS_W-1:0] slot;
      logic             complete;
      logic [CFG_W-1:0] n;
      logic [CFG_W-1:0] k;
   } load_ctl_type;

   typedef struct packed {
      logic [POS_W-1:0] source_pos;
      logic             last;
   } rsp_tag_type;

endpackage

### rtl/truncation_top_k_selector_unit.sv
// ----------------------------------------------------------------------------
// truncation_top_k_selector_unit
// Loads a population of (fitness, genes) and emits the select_count best.
// ----------------------------------------------------------------------------
// Requests enter on req_* (push/full): each stores one individual. The request
// that completes pop_size individuals starts a selection run. Results leave on
// rsp_* (empty/pop), best rank first, rsp_last on the final one. CSR writes
// (csr_valid/csr_ready, index 0 pop_size, 1 select_count) only while idle.
// A two-entry request queue parts the front (CSR, load count) from the back
// (store and selection sequencer), so loads keep flowing while the back works.
// While idle, the back stores one load per cycle. A run of n individuals and k
// ranks steps through start, then per rank head fetch, one compare/swap per
// cycle on the rank memory, gene read and emit. With the back idle, rsp_empty
// falls once the completing request has passed start, head fetch, scan (if
// n > 1), gene read and emit. A full response queue stalls the sequencer in
// its emit step; loads queue up and req_full rises once the request queue
// fills. Reset empties both queues, clears the load count and sets pop_size
// to 64, select_count to 32; store contents are not cleared.
// ----------------------------------------------------------------------------
module truncation_top_k_selector_unit #(
   parameter int POP_MAX   = tkss_pkg::POP_MAX_DEF,
   parameter int GENE_BITS = tkss_pkg::GENE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic signed [tkss_pkg::FIT_W-1:0] req_fitness,
   input  logic [GENE_BITS-1:0]              req_genes,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [GENE_BITS-1:0]              rsp_sel_genes,
   output logic signed [tkss_pkg::FIT_W-1:0] rsp_sel_fitness,
   output logic [tkss_pkg::POS_W-1:0]        rsp_source_pos,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tkss_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  logic [tkss_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int CTL_W  = $bits(tkss_pkg::load_ctl_type);
   localparam int TAG_W  = $bits(tkss_pkg::rsp_tag_type);
   localparam int FW     = tkss_pkg::FIT_W;
   localparam int LQ_W   = CTL_W + FW + GENE_BITS;
   localparam int RQ_W   = GENE_BITS + FW + TAG_W;

   tkss_pkg::load_ctl_type front_ctl, back_ctl;
   tkss_pkg::rsp_tag_type  out_tag, rsp_tag;

   logic             lq_push, lq_full, lq_pop, lq_empty;
   logic [LQ_W-1:0]  lq_din, lq_dout;
   logic             rq_push, rq_full;
   logic [RQ_W-1:0]  rq_din, rq_dout;
   logic [GENE_BITS-1:0] out_genes;
   logic [FW-1:0]        out_fitness;

   tkss_front #(
      .POP_MAX(POP_MAX)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .q_full   (lq_full),
      .q_push   (lq_push),
      .q_ctl    (front_ctl),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   assign req_full = lq_full;
   assign lq_din   = {front_ctl, req_fitness, req_genes};

   tkss_queue #(
      .W    (LQ_W),
      .DEPTH(tkss_pkg::QUEUE_DEPTH)
   ) u_load_queue (
      .clock(clock),
      .reset(reset),
      .push (lq_push),
      .din  (lq_din),
      .full (lq_full),
      .pop  (lq_pop),
      .dout (lq_dout),
      .empty(lq_empty)
   );

   assign back_ctl = lq_dout[LQ_W-1 -: CTL_W];

   tkss_back #(
      .POP_MAX  (POP_MAX),
      .GENE_BITS(GENE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (lq_empty),
      .q_pop      (lq_pop),
      .q_ctl      (back_ctl),
      .q_fitness  (lq_dout[GENE_BITS +: FW]),
      .q_genes    (lq_dout[GENE_BITS-1:0]),
      .out_full   (rq_full),
      .out_push   (rq_push),
      .out_genes  (out_genes),
      .out_fitness(out_fitness),
      .out_tag    (out_tag)
   );

   assign rq_din = {out_genes, out_fitness, out_tag};

   tkss_queue #(
      .W    (RQ_W),
      .DEPTH(tkss_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push (rq_push),
      .din  (rq_din),
      .full (rq_full),
      .pop  (rsp_pop),
      .dout (rq_dout),
      .empty(rsp_empty)
   );

   assign rsp_sel_genes   = rq_dout[RQ_W-1 -: GENE_BITS];
   assign rsp_sel_fitness = rq_dout[TAG_W +: FW];
   assign rsp_tag         = rq_dout[TAG_W-1:0];
   assign rsp_source_pos  = rsp_tag.source_pos;
   assign rsp_last        = rsp_tag.last;

endmodule

### rtl/tkss_queue.sv
// ----------------------------------------------------------------------------
// tkss_queue
// Small register FIFO with full/empty flags; DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module tkss_queue #(
   parameter int W     = 8,
   parameter int DEPTH = tkss_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] din,
   output logic         full,
   input  logic         pop,
   output logic [W-1:0] dout,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [W-1:0]     data_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

### rtl/tkss_front.sv
// ----------------------------------------------------------------------------
// tkss_front
// Configuration registers and load counter; tags each request with its slot
// and whether it completes the population.
// ----------------------------------------------------------------------------
module tkss_front #(
   parameter int POP_MAX = tkss_pkg::POP_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   input  logic                                q_full,
   output logic                                q_push,
   output tkss_pkg::load_ctl_type              q_ctl,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tkss_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [tkss_pkg::CFG_W-1:0]          csr_wdata
);

   localparam int IDX_W = $clog2(POP_MAX);
   localparam int CW    = tkss_pkg::CFG_W;

   logic [CW-1:0]    pop_size_ff, pop_size_in;
   logic [CW-1:0]    select_count_ff, select_count_in;
   logic [IDX_W-1:0] load_count_ff, load_count_in;
   logic [CW-1:0]    n_eff, k_eff, k_raw, count_inc;
   logic             complete, accept;

   assign csr_ready = 1'b1;

   always_comb begin
      pop_size_in     = pop_size_ff;
      select_count_in = select_count_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tkss_pkg::REG_POP_SIZE:     pop_size_in     = csr_wdata;
            tkss_pkg::REG_SELECT_COUNT: select_count_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (pop_size_ff == '0) begin
         n_eff = CW'(1);
      end else if (pop_size_ff > CW'(POP_MAX)) begin
         n_eff = CW'(POP_MAX);
      end else begin
         n_eff = pop_size_ff;
      end
      k_raw = (select_count_ff == '0) ? CW'(1) : select_count_ff;
      k_eff = (k_raw > n_eff) ? n_eff : k_raw;
   end

   assign count_inc = CW'(load_count_ff) + CW'(1);
   assign complete  = (count_inc >= n_eff);
   assign accept    = req_push && !q_full;
   assign q_push    = accept;

   always_comb begin
      q_ctl.slot     = tkss_pkg::POS_W'(load_count_ff);
      q_ctl.complete = complete;
      q_ctl.n        = n_eff;
      q_ctl.k        = k_eff;
   end

   always_comb begin
      load_count_in = load_count_ff;
      if (accept) begin
         load_count_in = complete ? '0 : load_count_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_size_ff     <= tkss_pkg::POP_SIZE_RST;
         select_count_ff <= tkss_pkg::SELECT_COUNT_RST;
         load_count_ff   <= '0;
      end else begin
         pop_size_ff     <= pop_size_in;
         select_count_ff <= select_count_in;
         load_count_ff   <= load_count_in;
      end
   end

endmodule

### rtl/tkss_back.sv
// ----------------------------------------------------------------------------
// tkss_back
// Population store and selection sequencer: one compare/swap per cycle over
// the rank list, then the winner of each rank goes to the response queue.
// ----------------------------------------------------------------------------
module tkss_back #(
   parameter int POP_MAX   = tkss_pkg::POP_MAX_DEF,
   parameter int GENE_BITS = tkss_pkg::GENE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_empty,
   output logic                              q_pop,
   input  tkss_pkg::load_ctl_type            q_ctl,
   input  logic [tkss_pkg::FIT_W-1:0]        q_fitness,
   input  logic [GENE_BITS-1:0]              q_genes,
   input  logic                              out_full,
   output logic                              out_push,
   output logic [GENE_BITS-1:0]              out_genes,
   output logic [tkss_pkg::FIT_W-1:0]        out_fitness,
   output tkss_pkg::rsp_tag_type             out_tag
);

   localparam int IDX_W = $clog2(POP_MAX);
   localparam int CNT_W = $clog2(POP_MAX + 1);
   localparam int FW    = tkss_pkg::FIT_W;

   tkss_pkg::back_state_type state_ff, state_in;

   logic [FW-1:0]        rec_fit_mem_ff  [POP_MAX];
   logic [IDX_W-1:0]     rec_src_mem_ff  [POP_MAX];
   logic [GENE_BITS-1:0] gene_mem_ff     [POP_MAX];

   logic [FW-1:0]        rec_fit_rd_ff;
   logic [IDX_W-1:0]     rec_src_rd_ff;
   logic [GENE_BITS-1:0] gene_rd_ff;

   logic [IDX_W-1:0]     j_ff, j_in, m_ff, m_in;
   logic [CNT_W-1:0]     n_ff, n_in, k_ff, k_in;
   logic [FW-1:0]        cur_fit_ff, cur_fit_in;
   logic [IDX_W-1:0]     cur_src_ff, cur_src_in;

   logic                 rec_we, gene_we;
   logic [IDX_W-1:0]     rec_waddr, rec_raddr;
   logic [FW-1:0]        rec_wfit;
   logic [IDX_W-1:0]     rec_wsrc;
   logic                 rec_ge, head_end, scan_end, rank_end;
   logic [CNT_W-1:0]     j_inc;

   assign rec_ge   = $signed(rec_fit_rd_ff) >= $signed(cur_fit_ff);
   assign j_inc    = CNT_W'(j_ff) + CNT_W'(1);
   assign head_end = (j_inc >= n_ff);
   assign scan_end = ((CNT_W'(m_ff) + CNT_W'(1)) >= n_ff);
   assign rank_end = (j_inc >= k_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tkss_pkg::ST_IDLE: begin
            if (!q_empty && q_ctl.complete) state_in = tkss_pkg::ST_START;
         end
         tkss_pkg::ST_START: state_in = tkss_pkg::ST_HEAD;
         tkss_pkg::ST_HEAD: begin
            state_in = head_end ? tkss_pkg::ST_GENE : tkss_pkg::ST_SCAN;
         end
         tkss_pkg::ST_SCAN: begin
            if (scan_end) state_in = tkss_pkg::ST_GENE;
         end
         tkss_pkg::ST_GENE: state_in = tkss_pkg::ST_EMIT;
         tkss_pkg::ST_EMIT: begin
            if (!out_full) state_in = rank_end ? tkss_pkg::ST_IDLE : tkss_pkg::ST_HEAD;
         end
         default: state_in = tkss_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      q_pop      = 1'b0;
      out_push   = 1'b0;
      rec_we     = 1'b0;
      gene_we    = 1'b0;
      rec_waddr  = m_ff;
      rec_wfit   = cur_fit_ff;
      rec_wsrc   = cur_src_ff;
      rec_raddr  = '0;
      j_in       = j_ff;
      m_in       = m_ff;
      n_in       = n_ff;
      k_in       = k_ff;
      cur_fit_in = cur_fit_ff;
      cur_src_in = cur_src_ff;
      unique case (state_ff)
         tkss_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop     = 1'b1;
               rec_we    = 1'b1;
               gene_we   = 1'b1;
               rec_waddr = q_ctl.slot[IDX_W-1:0];
               rec_wfit  = q_fitness;
               rec_wsrc  = q_ctl.slot[IDX_W-1:0];
               j_in      = '0;
               n_in      = CNT_W'(q_ctl.n);
               k_in      = CNT_W'(q_ctl.k);
            end
         end
         tkss_pkg::ST_START: rec_raddr = '0;
         tkss_pkg::ST_HEAD: begin
            cur_fit_in = rec_fit_rd_ff;
            cur_src_in = rec_src_rd_ff;
            rec_raddr  = j_ff + IDX_W'(1);
            m_in       = j_ff + IDX_W'(1);
         end
         tkss_pkg::ST_SCAN: begin
            rec_raddr = m_ff + IDX_W'(1);
            m_in      = m_ff + IDX_W'(1);
            if (rec_ge) begin
               rec_we     = 1'b1;
               cur_fit_in = rec_fit_rd_ff;
               cur_src_in = rec_src_rd_ff;
            end
         end
         tkss_pkg::ST_GENE: ;
         tkss_pkg::ST_EMIT: begin
            rec_raddr = j_ff + IDX_W'(1);
            if (!out_full) begin
               out_push = 1'b1;
               j_in     = j_ff + IDX_W'(1);
            end
         end
         default: ;
      endcase
   end

   assign out_genes          = gene_rd_ff;
   assign out_fitness        = cur_fit_ff;
   assign out_tag.source_pos = tkss_pkg::POS_W'(cur_src_ff);
   assign out_tag.last       = (j_inc == k_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tkss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff       <= j_in;
      m_ff       <= m_in;
      n_ff       <= n_in;
      k_ff       <= k_in;
      cur_fit_ff <= cur_fit_in;
      cur_src_ff <= cur_src_in;
   end

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_fit_mem_ff[rec_waddr] <= rec_wfit;
         rec_src_mem_ff[rec_waddr] <= rec_wsrc;
      end
      if (gene_we) begin
         gene_mem_ff[q_ctl.slot[IDX_W-1:0]] <= q_genes;
      end
      rec_fit_rd_ff <= rec_fit_mem_ff[rec_raddr];
      rec_src_rd_ff <= rec_src_mem_ff[rec_raddr];
      gene_rd_ff    <= gene_mem_ff[cur_src_ff];
   end

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == tkss_pkg::ST_SCAN |-> (m_ff > j_ff) && (CNT_W'(m_ff) < n_ff))
      else $error("scan index out of range");

   a_rank_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tkss_pkg::ST_IDLE && state_ff != tkss_pkg::ST_START)
      |-> (CNT_W'(j_ff) < k_ff) && (k_ff <= n_ff))
      else $error("rank beyond select count");

   a_emit_next: assert property (@(posedge clock) disable iff (reset)
      out_push |=> (state_ff == tkss_pkg::ST_IDLE || state_ff == tkss_pkg::ST_HEAD))
      else $error("bad state after emit");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == tkss_pkg::ST_IDLE && !out_push)
      else $error("load taken during selection");

endmodule
